>>> src/gaussian_blur_5x5_macros.svh
// Assertion macros shared by the 5x5 Gaussian blur RTL.
// Expects signals named clock and reset in the including module.
`ifndef GAUSSIAN_BLUR_5X5_MACROS_SVH
`define GAUSSIAN_BLUR_5X5_MACROS_SVH
`ifndef SYNTHESIS
`define GAU_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define GAU_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define GAU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define GAU_ASSERT(lbl, prop, msg)
`define GAU_ASSERT_IMPLY(lbl, ante, cons, msg)
`define GAU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> src/gau_pkg.sv
// Shared types and constants of the 5x5 Gaussian blur.
// No dependencies; used by every module of the block.
package gau_pkg;

   localparam int PIX_W  = 8;
   localparam int KSIZE  = 5;
   localparam int LINES  = KSIZE - 1;
   localparam int CFG_W  = 11;
   localparam int WGT_W  = 6;
   localparam int PSUM_W = 17;
   localparam int ACC_W  = 17;

   // divide by 330: q = (acc * DIV_MUL) >> DIV_SHIFT, exact for acc <= 84150
   localparam int DIV_SHIFT = 25;
   localparam logic [ACC_W-1:0] DIV_MUL = 17'd101681;
   localparam int PROD_W = 2 * ACC_W;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

   typedef enum logic [0:0] {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   // one window column, index 0 is the oldest row
   typedef logic [KSIZE-1:0][PIX_W-1:0] pix_col_type;
   typedef logic [KSIZE-1:0][WGT_W-1:0] wgt_col_type;

   typedef struct packed {
      logic             last;
      logic [PIX_W-1:0] pixel;
   } rsp_beat_type;

   // kernel columns; each column is symmetric top to bottom
   localparam wgt_col_type KERNEL_COL [KSIZE] = '{
      '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
      '{6'd4, 6'd20, 6'd33, 6'd20, 6'd4},
      '{6'd7, 6'd33, 6'd54, 6'd33, 6'd7},
      '{6'd4, 6'd20, 6'd33, 6'd20, 6'd4},
      '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
   };

endpackage

>>> src/gau_line_buf.sv
// Four line buffers packed side by side in one memory word per column.
// Depends on gau_pkg for pixel width and line count.
module gau_line_buf #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                       clock,
   input  logic                                       rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]               rd_addr,
   output logic [gau_pkg::LINES*gau_pkg::PIX_W-1:0]   rd_data,
   input  logic                                       wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]               wr_addr,
   input  logic [gau_pkg::LINES*gau_pkg::PIX_W-1:0]   wr_data
);

   logic [gau_pkg::LINES*gau_pkg::PIX_W-1:0] mem [MAX_WIDTH];
   logic [gau_pkg::LINES*gau_pkg::PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/gau_cell.sv
// One column of the 5x5 window: holds five pixels, hands them to its left
// neighbor on each shift and keeps a registered weighted sum. Uses gau_pkg.
module gau_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         shift_en,
   input  gau_pkg::pix_col_type         col_in,
   input  gau_pkg::wgt_col_type         col_weights,
   output gau_pkg::pix_col_type         col_out,
   output logic [gau_pkg::PSUM_W-1:0]   psum_out
);

   gau_pkg::pix_col_type              col_ff;
   logic [gau_pkg::PSUM_W-1:0]        psum_in;
   logic [gau_pkg::PSUM_W-1:0]        psum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (shift_en) begin
         col_ff <= col_in;
      end
   end

   always_comb begin
      psum_in = '0;
      for (int r = 0; r < gau_pkg::KSIZE; r++) begin
         psum_in = psum_in + gau_pkg::PSUM_W'(col_ff[r]) * gau_pkg::PSUM_W'(col_weights[r]);
      end
   end

   always_ff @(posedge clock) begin
      psum_ff <= psum_in;
   end

   assign col_out  = col_ff;
   assign psum_out = psum_ff;

endmodule

>>> src/gau_out_fifo.sv
// Small result queue between the filter pipeline and the output channel.
// Uses gau_pkg for the beat type and depth.
module gau_out_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  gau_pkg::rsp_beat_type push_beat,
   input  logic                  pop,
   output gau_pkg::rsp_beat_type head,
   output logic                  not_empty
);

   gau_pkg::rsp_beat_type           slot_ff [gau_pkg::FIFO_DEPTH];
   logic [gau_pkg::FIFO_AW-1:0]     wr_ptr_ff;
   logic [gau_pkg::FIFO_AW-1:0]     rd_ptr_ff;
   logic [gau_pkg::FIFO_AW:0]       count_ff;
   logic [gau_pkg::FIFO_AW:0]       count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_beat;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   assign head      = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);

endmodule

>>> src/gaussian_blur_5x5.sv
// 5x5 Gaussian blur of an 8-bit grayscale frame streamed in raster order, one pixel per clock.
// Frame width and height come from two APB registers (clamped to 5..MAX_WIDTH/MAX_HEIGHT);
// writing either restarts the frame. A result comes from the pixel that completes its window;
// pixels in the first four rows or columns give none, and tlast marks the frame's final result.
// The line buffers take one read and one write per cycle, and input stalls only when eight
// results are pending. Line buffer contents are not cleared by reset.
`include "gaussian_blur_5x5_macros.svh"

module gaussian_blur_5x5 #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] pixel_in
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] filtered_pixel
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int EWW  = ($clog2(MAX_WIDTH + 1) > gau_pkg::CFG_W) ?
                         $clog2(MAX_WIDTH + 1) : gau_pkg::CFG_W;
   localparam int EWH  = ($clog2(MAX_HEIGHT + 1) > gau_pkg::CFG_W) ?
                         $clog2(MAX_HEIGHT + 1) : gau_pkg::CFG_W;
   localparam int LBW  = gau_pkg::LINES * gau_pkg::PIX_W;
   localparam int PW   = gau_pkg::PIX_W;
   localparam int KS   = gau_pkg::KSIZE;

   // configuration
   logic [gau_pkg::CFG_W-1:0] width_ff;
   logic [gau_pkg::CFG_W-1:0] height_ff;
   logic                      cfg_wr;
   gau_pkg::reg_index_type    cfg_idx;

   // position and frame control
   logic [CW-1:0]  col_ff;
   logic [RW-1:0]  row_ff;
   logic [EWW-1:0] eff_w;
   logic [EWH-1:0] eff_h;
   logic           last_col;
   logic           last_row;
   logic           res_now;
   logic           last_now;
   logic           accept;

   // pipeline
   logic           v1_ff;
   logic           r1_ff, r2_ff, r3_ff, r4_ff;
   logic           l1_ff, l2_ff, l3_ff, l4_ff;
   logic [PW-1:0]  pix1_ff;
   logic [CW-1:0]  x1_ff;
   logic [LBW-1:0] lb_rd;
   logic [LBW-1:0] lb_wr;

   gau_pkg::pix_col_type       new_col;
   gau_pkg::pix_col_type       win_col [KS];
   logic [gau_pkg::PSUM_W-1:0] psum    [KS];
   logic [gau_pkg::ACC_W-1:0]  acc_in;
   logic [gau_pkg::ACC_W-1:0]  acc_ff;
   logic [gau_pkg::PROD_W-1:0] prod;

   // output side
   logic                           push;
   logic                           pop;
   gau_pkg::rsp_beat_type          push_beat;
   gau_pkg::rsp_beat_type          head;
   logic                           fifo_has;
   logic [gau_pkg::FIFO_AW:0]      pend_ff;
   logic [gau_pkg::FIFO_AW:0]      pend_in;

   // ---------------- configuration port ----------------
   assign cfg_idx    = gau_pkg::reg_index_type'(csr_paddr[2]);
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= gau_pkg::WIDTH_RESET;
         height_ff <= gau_pkg::HEIGHT_RESET;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            gau_pkg::REG_WIDTH:  width_ff  <= csr_pwdata[gau_pkg::CFG_W-1:0];
            gau_pkg::REG_HEIGHT: height_ff <= csr_pwdata[gau_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         gau_pkg::REG_WIDTH:  csr_prdata = 32'(width_ff);
         gau_pkg::REG_HEIGHT: csr_prdata = 32'(height_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // clamp the frame size to at least the kernel size and at most MAX_WIDTH by MAX_HEIGHT
   always_comb begin
      if (width_ff < gau_pkg::CFG_W'(KS)) begin
         eff_w = EWW'(KS);
      end else if (EWW'(width_ff) > EWW'(MAX_WIDTH)) begin
         eff_w = EWW'(MAX_WIDTH);
      end else begin
         eff_w = EWW'(width_ff);
      end
      if (height_ff < gau_pkg::CFG_W'(KS)) begin
         eff_h = EWH'(KS);
      end else if (EWH'(height_ff) > EWH'(MAX_HEIGHT)) begin
         eff_h = EWH'(MAX_HEIGHT);
      end else begin
         eff_h = EWH'(height_ff);
      end
   end

   // ---------------- input side and position ----------------
   assign req_tready = (pend_ff != (gau_pkg::FIFO_AW + 1)'(gau_pkg::FIFO_DEPTH));
   assign accept     = req_tvalid && req_tready;
   assign last_col   = (EWW'(col_ff) == eff_w - 1'b1);
   assign last_row   = (EWH'(row_ff) == eff_h - 1'b1);
   assign last_now   = last_col && last_row;
   assign res_now    = (col_ff >= CW'(gau_pkg::LINES)) && (row_ff >= RW'(gau_pkg::LINES));

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cfg_wr) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (last_col) begin
            col_ff <= '0;
            row_ff <= last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   // ---------------- line buffers ----------------
   gau_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (lb_rd),
      .wr_en   (v1_ff),
      .wr_addr (x1_ff),
      .wr_data (lb_wr)
   );

   // push the new pixel in as the newest line, drop the oldest
   assign lb_wr = {lb_rd[LBW-PW-1:0], pix1_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         r1_ff <= 1'b0;
         r2_ff <= 1'b0;
         r3_ff <= 1'b0;
         r4_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         r1_ff <= accept && res_now;
         r2_ff <= r1_ff;
         r3_ff <= r2_ff;
         r4_ff <= r3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix1_ff <= req_tdata;
         x1_ff   <= col_ff;
      end
      l1_ff <= last_now;
      l2_ff <= l1_ff;
      l3_ff <= l2_ff;
      l4_ff <= l3_ff;
   end

   // ---------------- window: chain of column cells ----------------
   always_comb begin
      for (int r = 0; r < gau_pkg::LINES; r++) begin
         new_col[r] = lb_rd[(gau_pkg::LINES - 1 - r) * PW +: PW];
      end
      new_col[KS-1] = pix1_ff;
   end

   for (genvar c = 0; c < KS; c++) begin : g_cell
      gau_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift_en    (v1_ff),
         .col_in      ((c == KS - 1) ? new_col : win_col[(c + 1) % KS]),
         .col_weights (gau_pkg::KERNEL_COL[c]),
         .col_out     (win_col[c]),
         .psum_out    (psum[c])
      );
   end

   always_comb begin
      acc_in = '0;
      for (int c = 0; c < KS; c++) begin
         acc_in = acc_in + psum[c];
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // divide by the kernel sum through a reciprocal multiply
   assign prod = gau_pkg::PROD_W'(acc_ff) * gau_pkg::PROD_W'(gau_pkg::DIV_MUL);

   assign push            = r4_ff;
   assign push_beat.pixel = prod[gau_pkg::DIV_SHIFT +: PW];
   assign push_beat.last  = l4_ff;

   // ---------------- output queue ----------------
   gau_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_beat (push_beat),
      .pop       (pop),
      .head      (head),
      .not_empty (fifo_has)
   );

   assign rsp_tvalid = fifo_has;
   assign rsp_tdata  = head.pixel;
   assign rsp_tlast  = head.last;
   assign pop        = rsp_tvalid && rsp_tready;

   // count results accepted but not yet delivered
   always_comb begin
      pend_in = pend_ff;
      if ((accept && res_now) && !pop) begin
         pend_in = pend_ff + 1'b1;
      end else if (pop && !(accept && res_now)) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // ---------------- assertions ----------------
   `GAU_ASSERT(a_pend_bound, pend_ff <= (gau_pkg::FIFO_AW + 1)'(gau_pkg::FIFO_DEPTH), "pending results exceed queue depth")
   `GAU_ASSERT_IMPLY(a_push_pending, push, pend_ff != '0, "result pushed with no pending credit")
   `GAU_ASSERT_IMPLY(a_valid_pending, rsp_tvalid, pend_ff != '0, "output beat without pending credit")
   `GAU_ASSERT_NEXT(a_frame_wrap, accept && last_now && !cfg_wr, (col_ff == '0) && (row_ff == '0), "position not cleared after last pixel")

endmodule
